// ===== rtl/eulr_pkg.sv =====
// Package for the three-axis point rotation unit.
// Holds widths, polynomial coefficients and shared types; no dependencies.
package eulr_pkg;

	localparam int COORD_BITS = 16;
	localparam int ANGLE_BITS = 16;
	localparam int TRIG_BITS  = 16;

	localparam logic [16:0] COEF_A = 17'd102944;
	localparam logic [16:0] COEF_B = 17'd42047;
	localparam logic [16:0] COEF_C = 17'd4640;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [ANGLE_BITS-1:0] angle_t;
	typedef logic signed [TRIG_BITS-1:0] trig_t;

endpackage

// ===== rtl/eulr_sincos.sv =====
// Pipelined sine/cosine generator, Q1.15 outputs.
// Depends on eulr_pkg. At most one multiply per stage.
module eulr_sincos
	import eulr_pkg::*;
(
	input  logic   clk,
	input  angle_t phase,
	output trig_t  sin_val,
	output trig_t  cos_val
);

	// Per-lane quadrant and within-quadrant argument (index 0 sine, 1 cosine).
	logic [1:0]  quad_s1 [2];
	logic [16:0] u_s1 [2];
	logic [1:0]  quad_s2 [2];
	logic [16:0] u_s2 [2];
	logic [16:0] u2_s2 [2];
	logic [1:0]  quad_s3 [2];
	logic [16:0] u_s3 [2];
	logic [16:0] u2_s3 [2];
	logic [16:0] inner_s3 [2];
	logic [1:0]  quad_s4 [2];
	logic [16:0] u_s4 [2];
	logic [16:0] mid_s4 [2];
	logic [1:0]  quad_s5 [2];
	logic [17:0] s_s5 [2];
	trig_t       res_s6 [2];

	for (genvar k = 0; k < 2; k++) begin : g_lane
		logic [31:0] p32;
		logic [15:0] t;
		logic [33:0] sq;
		logic [33:0] pc;
		logic [33:0] pi;
		logic [33:0] ps;
		logic [18:0] q;

		always_comb begin
			p32 = {phase, {(32-ANGLE_BITS){1'b0}}} + (k == 1 ? 32'h4000_0000 : 32'd0);
			t   = p32[29:14];
			sq  = u_s1[k] * u_s1[k] + 34'd32768;
			pc  = u2_s2[k] * COEF_C + 34'd32768;
			pi  = u2_s3[k] * inner_s3[k] + 34'd32768;
			ps  = u_s4[k] * mid_s4[k] + 34'd32768;
			q   = ({1'b0, s_s5[k]} + 19'd1) >> 1;
		end

		// Stage one folds the phase into the first quadrant.
		always_ff @(posedge clk) begin
			quad_s1[k] <= p32[31:30];
			u_s1[k]    <= p32[30] ? (17'd65536 - {1'b0, t}) : {1'b0, t};
		end

		// Square, then the nested Horner terms, one product per stage.
		always_ff @(posedge clk) begin
			quad_s2[k]  <= quad_s1[k];
			u_s2[k]     <= u_s1[k];
			u2_s2[k]    <= sq[32:16];
			quad_s3[k]  <= quad_s2[k];
			u_s3[k]     <= u_s2[k];
			u2_s3[k]    <= u2_s2[k];
			inner_s3[k] <= COEF_B - {1'b0, pc[31:16]};
			quad_s4[k]  <= quad_s3[k];
			u_s4[k]     <= u_s3[k];
			mid_s4[k]   <= COEF_A - pi[32:16];
			quad_s5[k]  <= quad_s4[k];
			s_s5[k]     <= ps[33:16];
		end

		// Scale to Q1.15, clip full scale and apply the sign of the quadrant.
		always_ff @(posedge clk) begin
			logic [15:0] mag;
			mag = (q > 19'd32767) ? 16'd32767 : q[15:0];
			res_s6[k] <= quad_s5[k][1] ? -$signed(mag) : $signed(mag);
		end
	end

	assign sin_val = res_s6[0];
	assign cos_val = res_s6[1];

endmodule

// ===== rtl/eulr_rot_stage.sv =====
// One plane rotation: a' = c*a - s*b, b' = s*a + c*b, rounded and saturated.
// Depends on eulr_pkg. Products registered, then sum, round and clip.
module eulr_rot_stage
	import eulr_pkg::*;
(
	input  logic   clk,
	input  coord_t a,
	input  coord_t b,
	input  trig_t  s,
	input  trig_t  c,
	output coord_t a_rot,
	output coord_t b_rot
);

	localparam int PW = COORD_BITS + TRIG_BITS;

	logic signed [PW-1:0] ca_s1, sb_s1, sa_s1, cb_s1;
	coord_t a_q, b_q;

	// Four products, one register level.
	always_ff @(posedge clk) begin
		ca_s1 <= c * a;
		sb_s1 <= s * b;
		sa_s1 <= s * a;
		cb_s1 <= c * b;
	end

	function automatic coord_t rnd_sat(input logic signed [PW:0] sum);
		logic signed [PW:0] v;
		logic signed [PW-15:0] r;
		v = sum + (PW+1)'(16384);
		r = v[PW:15];
		if (r > $signed((PW-14)'({1'b0, {(COORD_BITS-1){1'b1}}})))
			return {1'b0, {(COORD_BITS-1){1'b1}}};
		else if (r < -$signed((PW-14)'({1'b1, {(COORD_BITS-1){1'b0}}})))
			return {1'b1, {(COORD_BITS-1){1'b0}}};
		else
			return r[COORD_BITS-1:0];
	endfunction

	// Combine, round half up and saturate.
	always_ff @(posedge clk) begin
		a_q <= rnd_sat($signed({ca_s1[PW-1], ca_s1}) - $signed({sb_s1[PW-1], sb_s1}));
		b_q <= rnd_sat($signed({sa_s1[PW-1], sa_s1}) + $signed({cb_s1[PW-1], cb_s1}));
	end

	assign a_rot = a_q;
	assign b_rot = b_q;

endmodule

// ===== rtl/euler_xyz_point_rotation_unit.sv =====
// Top level of the three-axis Euler point rotation unit.
// Depends on eulr_pkg, eulr_sincos and eulr_rot_stage.
//
//  channel  | handshake         | payload
//  ---------+-------------------+------------------------------------------
//  command  | start / busy      | vert_x/y/z, angle_about_x/y/z
//  result   | done (strobe)     | rot_x, rot_y, rot_z
//
// One vertex is taken every cycle; busy is always low.
// The sine/cosine pipeline comes first, then one rotation stage per axis.
// The x-axis angle feeds its trig unit at once; later angles are delayed.
// Reset clears only the valid bits; payload registers are not reset.
// The receiver cannot stall, so no beat is ever held back.
module euler_xyz_point_rotation_unit
	import eulr_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	output logic   busy,
	input  coord_t vert_x,
	input  coord_t vert_y,
	input  coord_t vert_z,
	input  angle_t angle_about_x,
	input  angle_t angle_about_y,
	input  angle_t angle_about_z,
	output logic   done,
	output coord_t rot_x,
	output coord_t rot_y,
	output coord_t rot_z
);

	localparam int TRIG_LAT = 6;
	localparam int ROT_LAT  = 2;
	localparam int LAT      = TRIG_LAT + 3 * ROT_LAT;

	logic [LAT-1:0] vld_s;
	angle_t ay_d [ROT_LAT];
	angle_t az_d [2*ROT_LAT];
	coord_t x_d [TRIG_LAT];
	coord_t y_d [TRIG_LAT];
	coord_t z_d [TRIG_LAT];
	coord_t x1_d [ROT_LAT];
	coord_t y2_d [ROT_LAT];
	trig_t sx, cx, sy, cy, sz, cz;
	coord_t y1, z1, x2, z2, x3, y3, z2n;

	assign busy = 1'b0;

	// Valid bits travel beside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[LAT-2:0], start};
		end
	end

	// Delay lines that keep coordinates and later angles aligned.
	always_ff @(posedge clk) begin
		x_d[0] <= vert_x;
		y_d[0] <= vert_y;
		z_d[0] <= vert_z;
		for (int i = 1; i < TRIG_LAT; i++) begin
			x_d[i] <= x_d[i-1];
			y_d[i] <= y_d[i-1];
			z_d[i] <= z_d[i-1];
		end
		ay_d[0] <= angle_about_y;
		for (int i = 1; i < ROT_LAT; i++) ay_d[i] <= ay_d[i-1];
		az_d[0] <= angle_about_z;
		for (int i = 1; i < 2*ROT_LAT; i++) az_d[i] <= az_d[i-1];
		x1_d[0] <= x_d[TRIG_LAT-1];
		for (int i = 1; i < ROT_LAT; i++) x1_d[i] <= x1_d[i-1];
		y2_d[0] <= y1;
		for (int i = 1; i < ROT_LAT; i++) y2_d[i] <= y2_d[i-1];
	end

	eulr_sincos u_trig_x (.clk, .phase(angle_about_x), .sin_val(sx), .cos_val(cx));
	eulr_sincos u_trig_y (.clk, .phase(ay_d[ROT_LAT-1]), .sin_val(sy), .cos_val(cy));
	eulr_sincos u_trig_z (.clk, .phase(az_d[2*ROT_LAT-1]), .sin_val(sz), .cos_val(cz));

	// About x: y' = c*y - s*z, z' = s*y + c*z.
	eulr_rot_stage u_rot_x (.clk, .a(y_d[TRIG_LAT-1]), .b(z_d[TRIG_LAT-1]),
		.s(sx), .c(cx), .a_rot(y1), .b_rot(z1));

	// About y: z' = c*z - s*x, x' = s*z + c*x.
	eulr_rot_stage u_rot_y (.clk, .a(z1), .b(x1_d[ROT_LAT-1]),
		.s(sy), .c(cy), .a_rot(z2), .b_rot(x2));

	// About z: x' = c*x - s*y, y' = s*x + c*y.
	eulr_rot_stage u_rot_z (.clk, .a(x2), .b(y2_d[ROT_LAT-1]),
		.s(sz), .c(cz), .a_rot(x3), .b_rot(y3));

	// z is final after the y axis; hold it for the z-axis stage.
	always_ff @(posedge clk) begin
		z2n <= z2;
	end

	coord_t z2q;
	always_ff @(posedge clk) begin
		z2q <= z2n;
	end

	assign done  = vld_s[LAT-1];
	assign rot_x = x3;
	assign rot_y = y3;
	assign rot_z = z2q;

	// Result strobe follows an accepted command by the fixed latency.
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[0] |-> ##(LAT-1) done) else $error("result beat missing");
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s == '0) |=> !done) else $error("result beat without command");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy) else $error("unit stalled command beat");

endmodule

// ===== bench/euler_xyz_point_rotation_checker.sv =====
`timescale 1ns / 1ps
// Checker for the three-axis point rotation unit: watches command and result beats,
// predicts each rotated vertex and compares it field by field. Depends on eulr_pkg.
module euler_xyz_point_rotation_checker
	import eulr_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  logic   busy,
	input  coord_t vert_x,
	input  coord_t vert_y,
	input  coord_t vert_z,
	input  angle_t angle_about_x,
	input  angle_t angle_about_y,
	input  angle_t angle_about_z,
	input  logic   done,
	input  coord_t rot_x,
	input  coord_t rot_y,
	input  coord_t rot_z,
	output int     fail_count,
	output int     pending
);

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} vertex_t;

	vertex_t rotated_queue[$];

	// Polynomial sine of a 32-bit left-aligned phase, Q1.15.
	function automatic longint phase_sine(logic [31:0] p);
		logic [1:0] quad;
		longint t, u, u2, inner, mid, s, q;
		quad = p[31:30];
		t = p[29:14];
		u = quad[0] ? (65536 - t) : t;
		u2 = (u * u + 32768) >>> 16;
		inner = longint'(COEF_B) - ((u2 * longint'(COEF_C) + 32768) >>> 16);
		mid = longint'(COEF_A) - ((u2 * inner + 32768) >>> 16);
		s = (u * mid + 32768) >>> 16;
		q = (s + 1) >>> 1;
		if (q > 32767)
			q = 32767;
		return quad[1] ? -q : q;
	endfunction

	// Round a Q15-scaled sum back to coordinates, then saturate.
	function automatic longint round_clip(longint sum);
		longint r;
		r = (sum + 16384) >>> 15;
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return r;
	endfunction

	// Rotate about x, then y, then z.
	function automatic vertex_t rotate_vertex(coord_t vx, coord_t vy, coord_t vz,
			angle_t ax, angle_t ay, angle_t az);
		longint x, y, z, s, c, n0, n1;
		vertex_t r;
		x = vx;
		y = vy;
		z = vz;
		s = phase_sine({ax, 16'h0});
		c = phase_sine({ax, 16'h0} + 32'h4000_0000);
		n0 = round_clip(c * y - s * z);
		n1 = round_clip(s * y + c * z);
		y = n0;
		z = n1;
		s = phase_sine({ay, 16'h0});
		c = phase_sine({ay, 16'h0} + 32'h4000_0000);
		n0 = round_clip(c * x + s * z);
		n1 = round_clip(c * z - s * x);
		x = n0;
		z = n1;
		s = phase_sine({az, 16'h0});
		c = phase_sine({az, 16'h0} + 32'h4000_0000);
		n0 = round_clip(c * x - s * y);
		n1 = round_clip(s * x + c * y);
		r.x = coord_t'(n0);
		r.y = coord_t'(n1);
		r.z = coord_t'(z);
		return r;
	endfunction

	assign pending = rotated_queue.size();

	// Predict on each command beat, compare on each result beat.
	always @(posedge clk or negedge arst_n) begin
		vertex_t want;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (done) begin
				if (rotated_queue.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: result beat with nothing expected (%0d %0d %0d)",
							$realtime, rot_x, rot_y, rot_z);
					fail_count <= fail_count + 1;
				end else begin
					want = rotated_queue.pop_front();
					if (want.x !== rot_x || want.y !== rot_y || want.z !== rot_z) begin
						if (fail_count < 10)
							$display("%0t: mismatch exp (%0d %0d %0d) got (%0d %0d %0d)",
								$realtime, want.x, want.y, want.z, rot_x, rot_y, rot_z);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy)
				rotated_queue.push_back(rotate_vertex(vert_x, vert_y, vert_z,
					angle_about_x, angle_about_y, angle_about_z));
		end
	end

endmodule

// ===== bench/euler_xyz_point_rotation_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the three-axis point rotation unit: drives vertex beats with
// random gaps and gives the verdict. Depends on eulr_pkg and the checker module.
module euler_xyz_point_rotation_unit_tb;
	import eulr_pkg::*;

	logic   clk;
	logic   arst_n;
	logic   start;
	logic   busy;
	logic   done;
	coord_t vert_x, vert_y, vert_z;
	angle_t angle_about_x, angle_about_y, angle_about_z;
	coord_t rot_x, rot_y, rot_z;
	int     fail_count;
	int     pending;

	euler_xyz_point_rotation_unit dut (.*);

	euler_xyz_point_rotation_checker checker_inst (.*);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Send one vertex beat, after a random gap.
	task automatic send_vertex(coord_t x, coord_t y, coord_t z, angle_t ax, angle_t ay,
			angle_t az);
		int gap;
		gap = $urandom_range(0, 8);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		repeat (gap) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		vert_x <= x;
		vert_y <= y;
		vert_z <= z;
		angle_about_x <= ax;
		angle_about_y <= ay;
		angle_about_z <= az;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Draw a coordinate, often an extreme or near zero.
	function automatic coord_t pick_coord();
		case ($urandom_range(0, 5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return coord_t'($urandom_range(0, 64)) - 16'sd32;
			default: return coord_t'($urandom());
		endcase
	endfunction

	// Draw an angle, often on or next to a quarter turn.
	function automatic angle_t pick_angle();
		angle_t q;
		q = angle_t'($urandom_range(0, 3)) << 14;
		case ($urandom_range(0, 3))
			0: return q;
			1: return q + angle_t'($urandom_range(0, 4)) - 16'd2;
			default: return angle_t'($urandom());
		endcase
	endfunction

	initial begin
		int wait_cycles;
		arst_n = 1'b0;
		start = 1'b0;
		vert_x = '0;
		vert_y = '0;
		vert_z = '0;
		angle_about_x = '0;
		angle_about_y = '0;
		angle_about_z = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: extremes of coordinates, quarter-turn angles and saturation.
		send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'h0000, 16'h0000, 16'h0000);
		send_vertex(16'sh8000, 16'sh8000, 16'sh8000, 16'h0000, 16'h0000, 16'h0000);
		send_vertex(16'sh8000, 16'sh8000, 16'sh8000, 16'h8000, 16'h8000, 16'h8000);
		send_vertex(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'h4000, 16'hC000, 16'h4000);
		send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'h2000, 16'h2000, 16'h2000);
		send_vertex(16'sh8000, 16'sh7FFF, 16'sh8000, 16'hE000, 16'h6000, 16'hA000);
		send_vertex(16'sh0010, 16'sh0020, 16'sh0030, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_vertex(16'sh0000, 16'sh0000, 16'sh0000, 16'h5555, 16'hAAAA, 16'h1234);
		send_vertex(16'shFFFF, 16'sh0001, 16'shFFFF, 16'h0001, 16'h3FFF, 16'h4001);
		send_vertex(16'sh1234, 16'shEDCB, 16'sh5A5A, 16'h7FFF, 16'h8001, 16'hBFFF);
		send_vertex(16'sh7FFF, 16'sh0000, 16'sh0000, 16'h0000, 16'h0000, 16'h4000);
		send_vertex(16'sh0000, 16'sh7FFF, 16'sh0000, 16'h4000, 16'h0000, 16'h0000);

		// Random vertices and angles.
		repeat (1800)
			send_vertex(pick_coord(), pick_coord(), pick_coord(), pick_angle(), pick_angle(),
				pick_angle());
		start <= 1'b0;

		// Drain, then allow the pipeline latency once more.
		wait_cycles = 0;
		while (pending != 0 && wait_cycles < 1000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("euler_xyz_point_rotation_unit_tb OK");
		else
			$display("euler_xyz_point_rotation_unit_tb NOT OK");
		$finish;
	end

	// Watchdog.
	initial begin
		#2_000_000;
		$display("euler_xyz_point_rotation_unit_tb NOT OK");
		$finish;
	end

endmodule
